### hdl/tcce_pkg.sv
// Shared constants and types for the text console character engine.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned TAB_STEP = 8;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;

  localparam logic [7:0] COLOR_RESET = 8'h07;

  typedef enum logic [2:0] {
    MODE_PUT        = 3'd0,
    MODE_PUT_AT     = 3'd1,
    MODE_SET_CURSOR = 3'd2,
    MODE_CLEAR      = 3'd3,
    MODE_READ       = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_PASS = 3'b001,
    ST_IDLE = 3'b010,
    ST_READ = 3'b100
  } state_e;

endpackage

### hdl/text_console_char_engine.sv
// Text console character engine: cell store, cursor and put-char control.
// Depends on tcce_pkg.
`timescale 1ns / 1ps
//
//  channel   signals                                         direction
//  input     in_valid_i, in_stall_o, mode_i, char_code_i,    in
//            cell_color_i, column_i, row_i
//  output    out_valid_o, out_stall_i, cursor_column_o,      out
//            cursor_row_o, cursor_position_o, cell_value_o,
//            ignored_o, scrolled_o
//  config    cfg_we_i, cfg_wdata_i (text color)               in
//
//  Most beats register their result directly; a cell read goes through the registered memory read first.
//  Scroll and clear rewrite the whole store in a pass: one store entry is written per
//  cycle through the single write port of the cell memory.
//  After reset the store is blanked with color 0x07 in a pass over every entry;
//  no input beat is taken during that pass, config writes are.
//  A new beat is taken only once the previous result is gone or leaves that cycle.

module text_console_char_engine
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  cell_color_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_position_o,
  output logic [15:0] cell_value_o,
  output logic        ignored_o,
  output logic        scrolled_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned BASE  = CELLS - COLUMNS;
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(CELLS);

  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_A    = AW'(CELLS - 1);
  localparam logic [AW-1:0]  BASE_A    = AW'(BASE);
  localparam logic [AW:0]    CELLS_X   = (AW + 1)'(CELLS);
  localparam logic [AW:0]    AHEAD_X   = (AW + 1)'(COLUMNS + 1);
  localparam logic [ColW:0]  COLS_C    = (ColW + 1)'(COLUMNS);
  localparam logic [ColW:0]  TAB_C     = (ColW + 1)'(TAB_STEP);
  localparam logic [ColW:0]  TAB_MASK  = ~((ColW + 1)'(TAB_STEP - 1));
  localparam logic [RowW:0]  ROWS_C    = (RowW + 1)'(ROWS);
  localparam logic [RowW-1:0] LAST_ROW = RowW'(ROWS - 1);
  localparam logic [15:0]    BLANK_RST = {COLOR_RESET, CHAR_SPACE};

  // cell memory
  logic [15:0]   mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [15:0]   mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  state_e          state_q, state_d;
  logic [AW-1:0]   pass_q, pass_d;
  logic            scroll_q, scroll_d;
  logic            report_q, report_d;
  logic [15:0]     blank_q, blank_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [7:0]      color_q;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     cell_q, cell_d;
  logic            ign_q, ign_d;
  logic            scr_q, scr_d;

  logic            accept;
  logic [AW-1:0]   cur_pos;
  logic            in_range;
  logic [AW-1:0]   in_addr;
  logic [AW:0]     pass_ahead;

  // put-char cursor step
  logic [ColW:0]   pc_col;
  logic [RowW:0]   pc_row;
  logic            pc_write;
  logic            pc_scroll;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cur_pos  = AW'(AW'(row_q) * COLS_A) + AW'(col_q);
  assign in_range = (column_i < 8'(COLUMNS)) && (row_i < 8'(ROWS));
  assign in_addr  = AW'(AW'(row_i[RowW-1:0]) * COLS_A) + AW'(column_i[ColW-1:0]);
  assign pass_ahead = (AW + 1)'(pass_q) + AHEAD_X;

  always_comb begin
    pc_col   = {1'b0, col_q};
    pc_row   = {1'b0, row_q};
    pc_write = 1'b0;
    case (char_code_i)
      CHAR_LF: begin
        pc_col = '0;
        pc_row = pc_row + 1'b1;
      end
      CHAR_CR: begin
        pc_col = '0;
      end
      CHAR_TAB: begin
        pc_col = (pc_col + TAB_C) & TAB_MASK;
      end
      CHAR_BS: begin
        if (col_q != '0) begin
          pc_col = pc_col - 1'b1;
        end
      end
      default: begin
        if (char_code_i >= CHAR_SPACE && char_code_i <= CHAR_LAST) begin
          pc_write = 1'b1;
          pc_col   = pc_col + 1'b1;
        end
      end
    endcase
    if (pc_col >= COLS_C) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
    pc_scroll = (pc_row >= ROWS_C);
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    scroll_d    = scroll_q;
    report_d    = report_q;
    blank_d     = blank_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && out_stall_i;
    cell_d      = cell_q;
    ign_d       = ign_q;
    scr_d       = scr_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;

    case (state_q)
      ST_PASS: begin
        mem_we = 1'b1;
        mem_wa = pass_q;
        mem_wd = (scroll_q && pass_q < BASE_A) ? mem_rd_q : blank_q;
        if (pass_ahead < CELLS_X) begin
          mem_re = scroll_q;
          mem_ra = pass_ahead[AW-1:0];
        end
        pass_d = pass_q + 1'b1;
        if (pass_q == LAST_A) begin
          state_d = ST_IDLE;
          if (report_q) begin
            out_valid_d = 1'b1;
            cell_d      = '0;
            ign_d       = 1'b0;
            scr_d       = scroll_q;
          end
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        cell_d      = mem_rd_q;
        ign_d       = 1'b0;
        scr_d       = 1'b0;
      end
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          cell_d      = '0;
          ign_d       = 1'b0;
          scr_d       = 1'b0;
          case (mode_i)
            MODE_PUT: begin
              mem_we = pc_write;
              mem_wa = cur_pos;
              mem_wd = {color_q, char_code_i};
              col_d  = pc_col[ColW-1:0];
              row_d  = pc_scroll ? LAST_ROW : pc_row[RowW-1:0];
              if (pc_scroll) begin
                mem_re      = 1'b1;
                mem_ra      = COLS_A;
                out_valid_d = 1'b0;
                state_d     = ST_PASS;
                pass_d      = '0;
                scroll_d    = 1'b1;
                report_d    = 1'b1;
                blank_d     = {color_q, CHAR_SPACE};
              end
            end
            MODE_PUT_AT: begin
              mem_we = in_range;
              mem_wa = in_addr;
              mem_wd = {cell_color_i, char_code_i};
              ign_d  = !in_range;
            end
            MODE_SET_CURSOR: begin
              if (in_range) begin
                col_d = column_i[ColW-1:0];
                row_d = row_i[RowW-1:0];
              end
              ign_d = !in_range;
            end
            MODE_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              out_valid_d = 1'b0;
              state_d     = ST_PASS;
              pass_d      = '0;
              scroll_d    = 1'b0;
              report_d    = 1'b1;
              blank_d     = {color_q, CHAR_SPACE};
            end
            MODE_READ: begin
              if (in_range) begin
                mem_re      = 1'b1;
                mem_ra      = in_addr;
                out_valid_d = 1'b0;
                state_d     = ST_READ;
              end
              ign_d = !in_range;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PASS;
      pass_q      <= '0;
      scroll_q    <= 1'b0;
      report_q    <= 1'b0;
      blank_q     <= BLANK_RST;
      col_q       <= '0;
      row_q       <= '0;
      color_q     <= COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      scroll_q    <= scroll_d;
      report_q    <= report_d;
      blank_q     <= blank_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    ign_q  <= ign_d;
    scr_q  <= scr_d;
  end

  // cursor only moves on an accept, which also frees the output register
  assign out_valid_o       = out_valid_q;
  assign cursor_column_o   = 7'(col_q);
  assign cursor_row_o      = 5'(row_q);
  assign cursor_position_o = 11'(cur_pos);
  assign cell_value_o      = cell_q;
  assign ignored_o         = ign_q;
  assign scrolled_o        = scr_q;

endmodule
